@@ src/pspf_pkg.sv @@
// Package for the PID controller with setpoint prefilter.
// Holds the payload structs, register indexes and fixed-point constants.
// No dependencies.
package pspf_pkg;

   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 64;
   localparam int COEF_BITS = 30;

   localparam logic [CSR_AW-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_AW-1:0] REG_GAIN_I_DT  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_GAIN_D_FS  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_GAIN_FF_FS = 3'd3;
   localparam logic [CSR_AW-1:0] REG_OUT_LIMITS = 3'd4;
   localparam logic [CSR_AW-1:0] REG_FILTER     = 3'd5;
   localparam logic [CSR_AW-1:0] REG_RATE_LIM   = 3'd6;
   localparam logic [CSR_AW-1:0] REG_CONTROL    = 3'd7;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_RESET  = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [31:0] sensor;
      logic signed [31:0] setpoint_target;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               was_clamped;
   } rsp_type;

endpackage

@@ src/pid_with_setpoint_prefilter_top.sv @@
// PID controller with second-order setpoint prefilter, feedforward and anti-windup.
// Uses one multiplier. A new req beat is taken only after the last one has finished, and
// a held rsp stalls the last step; command and manual beats give no rsp. When anti-windup
// fires, the integral term and the sum are computed again before the rsp is given.
// Reset: synchronous, active high; clears the configuration and the controller state, the delay line needs no sweep.
// Depends on pspf_pkg.
module pid_with_setpoint_prefilter_top #(
   parameter int DELAY_DEPTH = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pspf_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pspf_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [pspf_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [pspf_pkg::CSR_DW-1:0]   csr_wdata
);
   import pspf_pkg::*;

   localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_INIT2 = 4'd2;
   localparam logic [3:0] S_F1    = 4'd3;
   localparam logic [3:0] S_F2    = 4'd4;
   localparam logic [3:0] S_F3    = 4'd5;
   localparam logic [3:0] S_F4    = 4'd6;
   localparam logic [3:0] S_E0    = 4'd7;
   localparam logic [3:0] S_E1    = 4'd8;
   localparam logic [3:0] S_E2    = 4'd9;
   localparam logic [3:0] S_E3    = 4'd10;
   localparam logic [3:0] S_E4    = 4'd11;
   localparam logic [3:0] S_E5    = 4'd12;
   localparam logic [3:0] S_E6    = 4'd13;
   localparam logic [3:0] S_E7    = 4'd14;
   localparam logic [3:0] S_E8    = 4'd15;

   localparam logic signed [67:0] TERM_LIM = 68'sd1 <<< 47;
   localparam logic signed [67:0] I_CAP    = 68'sd1 <<< (23 + FRAC_BITS);

   function automatic logic signed [67:0] rnd_shift(input logic signed [65:0] p, input int s);
      logic signed [67:0] w;
      w = 68'(p) + (68'sd1 <<< (s - 1));
      return w >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      logic signed [31:0] r;
      if (x > 68'sd2147483647) r = 32'sh7fffffff;
      else if (x < -68'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [49:0] lim47(input logic signed [67:0] x);
      logic signed [49:0] r;
      if (x > TERM_LIM) r = TERM_LIM[49:0];
      else if (x < -TERM_LIM) r = -TERM_LIM[49:0];
      else r = x[49:0];
      return r;
   endfunction

   // configuration
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff, gain_ff_ff;
   logic [63:0]        limits_ff, coeffs_ff, rates_ff;
   logic [7:0]         control_ff;
   logic               prior_mode_ff;

   // controller state
   logic               initialized_ff;
   logic signed [47:0] acc_ff, accn_ff;
   logic signed [31:0] prev_ff, frs_ff, slope_ff, newest_ff, init_val_ff;
   logic [AW-1:0]      rp_ff;
   logic [AW:0]        fill_ff;
   logic [31:0]        dmem [DELAY_DEPTH];
   logic [31:0]        rd_ff;
   logic               use_init_ff, use_newest_ff;

   // per-beat working registers
   logic [3:0]         step_ff;
   logic signed [31:0] sensor_ff, target_ff, err_ff;
   logic signed [65:0] prod_ff, x_ff;
   logic               xhi_ff, xlo_ff, redo_ff;
   logic signed [49:0] p_ff, i_ff, d_ff, ffw_ff;
   logic signed [51:0] sum_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // derived values
   logic signed [31:0] c1, c2, rlo, rhi, olo, ohi;
   logic signed [32:0] op_a, op_b;
   logic [10:0]        dl_wide;
   logic [AW-1:0]      dl, rp_in, raddr;
   logic [AW:0]        fill_in, raddr_tmp;
   logic signed [31:0] filtered, slope_in, integ;
   logic signed [67:0] fr_tmp, x_tmp, r_tmp;
   logic signed [51:0] lo_w, hi_w;
   logic               out_of, same_sign, req_acc, rsp_load;

   assign c1  = coeffs_ff[63:32];
   assign c2  = coeffs_ff[31:0];
   assign rlo = rates_ff[63:32];
   assign rhi = rates_ff[31:0];
   assign olo = limits_ff[63:32];
   assign ohi = limits_ff[31:0];
   assign lo_w = 52'(olo);
   assign hi_w = 52'(ohi);

   assign req_ready = (step_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dl_wide = {5'd0, control_ff[7:2]};
   assign dl = (dl_wide > 11'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1) : dl_wide[AW-1:0];
   assign rp_in = (rp_ff == AW'(DELAY_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign fill_in = (fill_ff == (AW+1)'(DELAY_DEPTH)) ? fill_ff : fill_ff + 1'b1;
   assign raddr_tmp = {1'b0, rp_in} + (AW+1)'(DELAY_DEPTH) - {1'b0, dl};
   assign raddr = (raddr_tmp >= (AW+1)'(DELAY_DEPTH)) ?
                  AW'(raddr_tmp - (AW+1)'(DELAY_DEPTH)) : raddr_tmp[AW-1:0];
   assign integ = sat32(68'(newest_ff) + 68'(slope_ff));

   always_comb begin
      if (!control_ff[1]) filtered = target_ff;
      else if (use_init_ff) filtered = init_val_ff;
      else if (use_newest_ff) filtered = newest_ff;
      else filtered = rd_ff;
   end

   always_comb begin
      fr_tmp = 68'(frs_ff) - rnd_shift(prod_ff, COEF_BITS);
      slope_in = sat32(fr_tmp);
      if (slope_in > rhi) slope_in = rhi;
      if (slope_in < rlo) slope_in = rlo;
   end

   always_comb begin
      x_tmp = 68'(x_ff) <<< (24 - FRAC_BITS);
      r_tmp = x_tmp + rnd_shift(prod_ff, FRAC_BITS);
   end

   assign out_of = (sum_ff < lo_w) || (sum_ff > hi_w);
   assign same_sign = (err_ff > 0 && sum_ff > 0) || (err_ff < 0 && sum_ff < 0);
   assign rsp_load = (step_ff == S_E8) && !(out_of && same_sign && !redo_ff) &&
                     (!rsp_valid_ff || rsp_ready);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         S_INIT: begin op_a = 33'(c2);        op_b = 33'(sensor_ff); end
         S_F1:   begin op_a = 33'(c1);        op_b = 33'(target_ff) - 33'(newest_ff); end
         S_F2:   begin op_a = 33'(c2);        op_b = 33'(newest_ff); end
         S_E1:   begin op_a = 33'(gain_p_ff); op_b = 33'(err_ff); end
         S_E2:   begin op_a = 33'(gain_d_ff); op_b = 33'(err_ff) - 33'(prev_ff); end
         S_E3:   begin op_a = 33'(gain_ff_ff); op_b = 33'(slope_ff); end
         S_E4:   begin op_a = 33'(gain_i_ff); op_b = 33'(signed'(accn_ff[47:24])); end
         S_E5:   begin op_a = 33'(gain_i_ff); op_b = {9'd0, accn_ff[23:0]}; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // delay line: one write, one registered read
   always_ff @(posedge clock) begin
      if (step_ff == S_F4) begin
         dmem[rp_in] <= integ;
      end
      rd_ff <= dmem[raddr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (reset) begin
         gain_p_ff <= '0; gain_i_ff <= '0; gain_d_ff <= '0; gain_ff_ff <= '0;
         limits_ff <= '0; coeffs_ff <= '0; rates_ff <= '0; control_ff <= '0;
         prior_mode_ff <= 1'b0; initialized_ff <= 1'b0;
         acc_ff <= '0; accn_ff <= '0; prev_ff <= '0; frs_ff <= '0; slope_ff <= '0;
         newest_ff <= '0; rp_ff <= '0; fill_ff <= '0;
         step_ff <= S_IDLE; rsp_valid_ff <= 1'b0; redo_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_addr)
               REG_GAIN_P:     gain_p_ff  <= csr_wdata[31:0];
               REG_GAIN_I_DT:  gain_i_ff  <= csr_wdata[31:0];
               REG_GAIN_D_FS:  gain_d_ff  <= csr_wdata[31:0];
               REG_GAIN_FF_FS: gain_ff_ff <= csr_wdata[31:0];
               REG_OUT_LIMITS: limits_ff  <= csr_wdata;
               REG_FILTER:     coeffs_ff  <= csr_wdata;
               REG_RATE_LIM:   rates_ff   <= csr_wdata;
               REG_CONTROL: begin
                  control_ff <= csr_wdata[7:0];
                  if (csr_wdata[0] && !prior_mode_ff) initialized_ff <= 1'b0;
                  prior_mode_ff <= csr_wdata[0];
               end
               default: ;
            endcase
         end
         case (step_ff)
            S_IDLE: begin
               if (req_acc) begin
                  sensor_ff <= req_data.sensor;
                  target_ff <= req_data.setpoint_target;
                  redo_ff   <= 1'b0;
                  if (req_data.command == CMD_RESET) begin
                     acc_ff <= '0; prev_ff <= '0; frs_ff <= '0; newest_ff <= '0;
                     initialized_ff <= 1'b0;
                  end else if (control_ff[0]) begin
                     if (!initialized_ff) step_ff <= S_INIT;
                     else if (control_ff[1]) step_ff <= S_F1;
                     else step_ff <= S_E0;
                  end
               end
            end
            S_INIT: begin
               newest_ff <= sensor_ff; init_val_ff <= sensor_ff; fill_ff <= '0;
               acc_ff <= '0; prev_ff <= '0; initialized_ff <= 1'b1;
               step_ff <= S_INIT2;
            end
            S_INIT2: begin
               frs_ff  <= sat32(rnd_shift(prod_ff, COEF_BITS));
               step_ff <= control_ff[1] ? S_F1 : S_E0;
            end
            S_F1: step_ff <= S_F2;
            S_F2: begin
               frs_ff  <= sat32(68'(frs_ff) + rnd_shift(prod_ff, COEF_BITS));
               step_ff <= S_F3;
            end
            S_F3: begin
               slope_ff <= slope_in;
               step_ff  <= S_F4;
            end
            S_F4: begin
               rp_ff <= rp_in; fill_ff <= fill_in; newest_ff <= integ;
               use_init_ff   <= ({1'b0, dl} >= fill_in);
               use_newest_ff <= (dl == '0);
               step_ff <= S_E0;
            end
            S_E0: begin
               err_ff  <= sat32(68'(filtered) - 68'(sensor_ff));
               step_ff <= S_E1;
            end
            S_E1: begin
               if (49'(acc_ff) + 49'(err_ff) > 49'sh7fffffffffff) accn_ff <= 48'sh7fffffffffff;
               else if (49'(acc_ff) + 49'(err_ff) < -49'sh800000000000)
                  accn_ff <= 48'sh800000000000;
               else accn_ff <= acc_ff + 48'(err_ff);
               step_ff <= S_E2;
            end
            S_E2: begin p_ff <= lim47(rnd_shift(prod_ff, FRAC_BITS)); step_ff <= S_E3; end
            S_E3: begin d_ff <= lim47(rnd_shift(prod_ff, FRAC_BITS)); step_ff <= S_E4; end
            S_E4: begin
               if (!redo_ff) ffw_ff <= lim47(rnd_shift(prod_ff, FRAC_BITS));
               step_ff <= S_E5;
            end
            S_E5: begin
               x_ff    <= prod_ff;
               xhi_ff  <= 68'(prod_ff) > I_CAP;
               xlo_ff  <= 68'(prod_ff) < -I_CAP;
               step_ff <= S_E6;
            end
            S_E6: begin
               if (xhi_ff) i_ff <= TERM_LIM[49:0];
               else if (xlo_ff) i_ff <= -TERM_LIM[49:0];
               else i_ff <= lim47(r_tmp);
               step_ff <= S_E7;
            end
            S_E7: begin
               sum_ff  <= 52'(p_ff) + 52'(i_ff) + 52'(d_ff) + 52'(ffw_ff);
               step_ff <= S_E8;
            end
            S_E8: begin
               if (out_of && same_sign && !redo_ff) begin
                  accn_ff <= acc_ff; redo_ff <= 1'b1;
                  step_ff <= S_E4;
               end else if (rsp_load) begin
                  acc_ff  <= accn_ff;
                  prev_ff <= err_ff;
                  if (sum_ff < lo_w) rsp_ff.drive <= olo;
                  else if (sum_ff > hi_w) rsp_ff.drive <= ohi;
                  else rsp_ff.drive <= sum_ff[31:0];
                  rsp_ff.was_clamped <= out_of;
                  step_ff <= S_IDLE;
               end
            end
            default: step_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ src/pspf_checker.sv @@
// Port-level checker for the PID controller with setpoint prefilter, with its bind.
// Depends on pspf_pkg and pid_with_setpoint_prefilter_top.
module pspf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input pspf_pkg::req_type           req_data,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input pspf_pkg::rsp_type           rsp_data
);
   import pspf_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed");

   a_cmd_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_RESET && !rsp_valid |=> !rsp_valid)
      else $error("reset command gave a rsp beat");

   a_busy_after_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> !$past(req_ready))
      else $error("rsp beat raised while idle");

endmodule

bind pid_with_setpoint_prefilter_top pspf_checker u_pspf_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

@@ dv/pid_with_setpoint_prefilter_top_tb.sv @@
// Testbench for pid_with_setpoint_prefilter_top: random and directed sample and reset-command beats,
// an in-class predictor of the PID and prefilter datapath, and a result scoreboard.
// Depends on pspf_pkg and the top-level RTL.
`timescale 1ns / 100ps

module pid_with_setpoint_prefilter_top_tb;
   import pspf_pkg::*;

   localparam longint TERM_LIM = 64'sd1 << 47;
   localparam longint ACC_MAX  = (64'sd1 << 47) - 1;
   localparam longint ACC_MIN  = -(64'sd1 << 47);
   localparam longint S32_MAX  = 64'sd2147483647;
   localparam longint S32_MIN  = -64'sd2147483648;
   localparam int     DEPTH    = 64;
   localparam int     FRAC     = 16;
   localparam int     WATCHDOG_LIMIT = 3000;
   localparam int     SETTLE_CYCLES  = 40;

   class pid_scoreboard;
      logic [63:0] regs [8];
      longint      integ_acc, prev_err, rate_state, slope_held, newest;
      longint      delay_line [DEPTH];
      int          ring_ptr;
      bit          primed, auto_prev;
      rsp_type     expected_drive [$];
      int          errors, results_seen, clamps_seen, windup_hits;

      function new();
         foreach (regs[k]) regs[k] = '0;
         integ_acc = 0; prev_err = 0; rate_state = 0; slope_held = 0; newest = 0;
         foreach (delay_line[k]) delay_line[k] = 0;
         ring_ptr = 0; primed = 0; auto_prev = 0;
         errors = 0; results_seen = 0; clamps_seen = 0; windup_hits = 0;
      endfunction

      function longint s32(logic [31:0] v);
         return longint'(signed'(v));
      endfunction

      function longint clip(longint x, longint lo, longint hi);
         return x < lo ? lo : (x > hi ? hi : x);
      endfunction

      function longint sat32(longint x);
         return clip(x, S32_MIN, S32_MAX);
      endfunction

      function longint rnd_mul(longint a, longint b, int s);
         logic signed [127:0] pr;
         pr = 128'(signed'(a)) * 128'(signed'(b)) + (128'sd1 <<< (s - 1));
         return longint'(pr >>> s);
      endfunction

      function longint gain_term(longint a, longint b);
         return clip(rnd_mul(a, b, FRAC), -TERM_LIM, TERM_LIM);
      endfunction

      function longint integ_term(longint a, longint b);
         longint lo_part, hi_part, x, y, cap, r;
         lo_part = b & 64'hFFFFFF;
         hi_part = b >>> 24;
         x = a * hi_part;
         y = a * lo_part;
         cap = TERM_LIM >>> (24 - FRAC);
         if (x > cap) return TERM_LIM;
         if (x < -cap) return -TERM_LIM;
         r = x * (64'sd1 << (24 - FRAC)) + rnd_mul(y, 1, FRAC);
         return clip(r, -TERM_LIM, TERM_LIM);
      endfunction

      function void write_reg(logic [CSR_AW-1:0] idx, logic [63:0] val);
         regs[idx] = val;
         if (idx == REG_CONTROL) begin
            if (val[0] && !auto_prev) primed = 0;
            auto_prev = val[0];
         end
      endfunction

      function void note_request(req_type r);
         longint sensor, target, filtered, err, acc_old, acc_new;
         longint p, i, d, ff, sum, lo, hi, drive, c1, c2, back, slope, smin, smax;
         int dl;
         rsp_type e;
         if (r.command == CMD_RESET) begin
            integ_acc = 0; prev_err = 0; rate_state = 0; newest = 0; primed = 0;
            return;
         end
         if (!regs[REG_CONTROL][0]) return;
         sensor = s32(r.sensor);
         target = s32(r.setpoint_target);
         if (!primed) begin
            foreach (delay_line[k]) delay_line[k] = sensor;
            newest = sensor;
            rate_state = sat32(rnd_mul(s32(regs[REG_FILTER][31:0]), sensor, COEF_BITS));
            integ_acc = 0; prev_err = 0; primed = 1;
         end
         if (regs[REG_CONTROL][1]) begin
            c1 = s32(regs[REG_FILTER][63:32]);
            c2 = s32(regs[REG_FILTER][31:0]);
            smin = s32(regs[REG_RATE_LIM][63:32]);
            smax = s32(regs[REG_RATE_LIM][31:0]);
            back = newest;
            dl = regs[REG_CONTROL][7:2];
            if (dl > DEPTH - 1) dl = DEPTH - 1;
            rate_state = sat32(rate_state + rnd_mul(c1, target - back, COEF_BITS));
            slope = sat32(rate_state - rnd_mul(c2, back, COEF_BITS));
            slope = clip(slope, smin, smax);
            if (slope < smin) slope = smin;
            slope_held = slope;
            ring_ptr = (ring_ptr + 1) % DEPTH;
            delay_line[ring_ptr] = sat32(back + slope);
            newest = delay_line[ring_ptr];
            filtered = delay_line[(ring_ptr + DEPTH - dl) % DEPTH];
         end else begin
            filtered = target;
         end
         err = sat32(filtered - sensor);
         p = gain_term(s32(regs[REG_GAIN_P][31:0]), err);
         d = gain_term(s32(regs[REG_GAIN_D_FS][31:0]), err - prev_err);
         ff = gain_term(s32(regs[REG_GAIN_FF_FS][31:0]), slope_held);
         acc_old = integ_acc;
         acc_new = clip(acc_old + err, ACC_MIN, ACC_MAX);
         i = integ_term(s32(regs[REG_GAIN_I_DT][31:0]), acc_new);
         sum = p + i + d + ff;
         lo = s32(regs[REG_OUT_LIMITS][63:32]);
         hi = s32(regs[REG_OUT_LIMITS][31:0]);
         if ((sum < lo || sum > hi) && ((err > 0 && sum > 0) || (err < 0 && sum < 0))) begin
            acc_new = acc_old;
            i = integ_term(s32(regs[REG_GAIN_I_DT][31:0]), acc_new);
            sum = p + i + d + ff;
            windup_hits++;
         end
         integ_acc = acc_new;
         drive = sum > hi ? hi : sum;
         if (sum < lo) drive = lo;
         prev_err = err;
         e.drive = drive[31:0];
         e.was_clamped = (sum < lo || sum > hi);
         expected_drive.insert(expected_drive.size(), e);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(rsp_type got);
         rsp_type e;
         results_seen++;
         if (got.was_clamped) clamps_seen++;
         if (expected_drive.size() == 0) begin
            report($sformatf("unexpected result drive=%h", got.drive));
            return;
         end
         e = expected_drive[0];
         expected_drive.delete(0);
         if (got.drive !== e.drive)
            report($sformatf("drive %h, want %h", got.drive, e.drive));
         if (got.was_clamped !== e.was_clamped)
            report($sformatf("was_clamped %b, want %b", got.was_clamped, e.was_clamped));
      endtask

      function int pending();
         return expected_drive.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_AW-1:0]   csr_addr;
   logic [CSR_DW-1:0]   csr_wdata;

   pid_scoreboard sb = new();
   int  beats_sent;
   int  idle_cycles;
   bit  hold_rsp;
   bit  steady_rsp;
   int  stall_left;

   pid_with_setpoint_prefilter_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (hold_rsp) begin
            hold_rsp = 0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (steady_rsp || $urandom_range(0, 9) < 7) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task send_beat(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      beats_sent++;
   endtask

   task pause_sender(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task random_gap(bit no_gaps);
      if (!no_gaps) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: pause_sender($urandom_range(1, 3));
            6:                pause_sender($urandom_range(15, 40));
            default:          ;
         endcase
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_regs(logic [63:0] vals [8]);
      for (int k = 0; k < 8; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_AW'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
         sb.write_reg(CSR_AW'(k), vals[k]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task write_one(logic [CSR_AW-1:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFFFFFF;
         1:       return 32'h80000000;
         2, 3:    return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h01FFFFF)) - 32'sh0100000);
      endcase
   endfunction

   function logic [31:0] pick_gain();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'h0;
         default: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      endcase
   endfunction

   function req_type make_beat(int reset_pct);
      req_type r;
      r.command = ($urandom_range(0, 99) < reset_pct) ? CMD_RESET : CMD_SAMPLE;
      r.sensor = pick_value();
      r.setpoint_target = pick_value();
      return r;
   endfunction

   task random_config(output logic [63:0] v [8]);
      logic [31:0] a, b;
      v[REG_GAIN_P]     = pick_gain();
      v[REG_GAIN_I_DT]  = pick_gain();
      v[REG_GAIN_D_FS]  = pick_gain();
      v[REG_GAIN_FF_FS] = ($urandom_range(0, 3) == 0) ? 32'h0 : pick_gain();
      a = pick_value();
      b = pick_value();
      v[REG_OUT_LIMITS] = ($urandom_range(0, 4) == 0) ? {a, b}
                        : {-($urandom_range(1, 32'h7FFFFF)), 32'($urandom_range(1, 32'h7FFFFF))};
      v[REG_FILTER] = ($urandom_range(0, 5) == 0) ? {$urandom(), $urandom()}
                    : {32'($urandom_range(0, 32'h4000000)), 32'($urandom_range(0, 32'h10000000))};
      v[REG_RATE_LIM] = ($urandom_range(0, 4) == 0) ? {pick_value(), pick_value()}
                      : {-($urandom_range(1, 32'h3FFFFF)), 32'($urandom_range(1, 32'h3FFFFF))};
      v[REG_CONTROL] = {56'h0, 6'($urandom()), 1'($urandom_range(0, 3) != 0),
                        1'($urandom_range(0, 7) != 0)};
   endtask

   initial begin
      logic [63:0] cfg [8];
      req_type     r;
      int          phase, n;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_addr  <= '0;
      csr_wdata <= '0;
      beats_sent = 0;
      hold_rsp = 0;
      steady_rsp = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unity P gain, prefilter on with zero delay, then the corner cases
      cfg[REG_GAIN_P]     = 32'h00010000;
      cfg[REG_GAIN_I_DT]  = 32'h00001000;
      cfg[REG_GAIN_D_FS]  = 32'h00008000;
      cfg[REG_GAIN_FF_FS] = 32'h00002000;
      cfg[REG_OUT_LIMITS] = {32'hFF9C0000, 32'h00640000};
      cfg[REG_FILTER]     = {32'h00400000, 32'h02000000};
      cfg[REG_RATE_LIM]   = {32'hFFFF0000, 32'h00010000};
      cfg[REG_CONTROL]    = 64'h03;
      write_regs(cfg);
      send_beat('{CMD_SAMPLE, 32'sh00050000, 32'sh000A0000});
      send_beat('{CMD_SAMPLE, 32'sh00050000, 32'sh000A0000});
      send_beat('{CMD_SAMPLE, 32'sh7FFFFFFF, 32'sh80000000});
      send_beat('{CMD_SAMPLE, 32'sh80000000, 32'sh7FFFFFFF});
      send_beat('{CMD_RESET,  32'sh00010000, 32'sh00020000});
      send_beat('{CMD_SAMPLE, 32'sh00010000, 32'sh00020000});
      send_beat('{CMD_SAMPLE, 32'sh00000000, 32'sh00000000});
      drain();
      write_one(REG_CONTROL, 64'hFF);
      send_beat('{CMD_SAMPLE, 32'sh00010000, 32'sh00200000});
      send_beat('{CMD_SAMPLE, 32'shFFFF0000, 32'sh7FFFFFFF});
      drain();
      write_one(REG_CONTROL, 64'h00);
      send_beat('{CMD_SAMPLE, 32'sh00030000, 32'sh00040000});
      drain();
      write_one(REG_CONTROL, 64'h01);
      write_one(REG_OUT_LIMITS, {32'h00100000, 32'hFFF00000});
      write_one(REG_GAIN_P, 64'h7FFFFFFF);
      write_one(REG_GAIN_I_DT, 64'h7FFFFFFF);
      send_beat('{CMD_SAMPLE, 32'sh00000000, 32'sh7FFFFFFF});
      send_beat('{CMD_SAMPLE, 32'sh00000000, 32'sh7FFFFFFF});
      send_beat('{CMD_SAMPLE, 32'sh7FFFFFFF, 32'sh80000000});
      drain();
      write_one(REG_OUT_LIMITS, {32'hFFFF0000, 32'h00010000});
      write_one(REG_GAIN_P, 64'h80000000);
      write_one(REG_GAIN_I_DT, 64'h80000000);
      write_one(REG_GAIN_D_FS, 64'h7FFFFFFF);
      write_one(REG_GAIN_FF_FS, 64'h80000000);
      write_one(REG_RATE_LIM, {32'h00020000, 32'hFFFE0000});
      write_one(REG_FILTER, {32'h7FFFFFFF, 32'h80000000});
      write_one(REG_CONTROL, 64'h03);
      send_beat('{CMD_SAMPLE, 32'sh00100000, 32'sh80000000});
      send_beat('{CMD_SAMPLE, 32'shFFF00000, 32'sh7FFFFFFF});
      send_beat('{CMD_SAMPLE, 32'sh80000000, 32'sh80000000});
      send_beat('{CMD_SAMPLE, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
      drain();

      // random phases with fresh register settings
      phase = 0;
      while (beats_sent < 850) begin
         random_config(cfg);
         if (phase == 1) cfg[REG_CONTROL][0] = 1'b0;
         write_regs(cfg);
         steady_rsp = (phase % 4 == 3);
         if (phase == 2) hold_rsp = 1;
         n = $urandom_range(50, 90);
         for (int k = 0; k < n; k++) begin
            r = make_beat(4);
            send_beat(r);
            if (k == n / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (sb.pending() != 0) @(posedge clock);
            end else begin
               random_gap(phase == 2 || phase % 5 == 4);
            end
         end
         drain();
         // keep running but move the delay tap
         if (phase % 3 == 0) begin
            write_one(REG_CONTROL, {56'h0, 6'($urandom()), 2'b11});
            for (int k = 0; k < 10; k++) send_beat(make_beat(0));
            drain();
         end
         phase++;
      end

      drain();
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      $display("covered %0d input beats over %0d register settings", beats_sent, phase + 5);
      $display("checked %0d results, %0d clamped, %0d with integration undone",
               sb.results_seen, sb.clamps_seen, sb.windup_hits);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
